// ===== sv/m61h_pkg.sv =====
package m61h_pkg;

  localparam int unsigned FieldW = 61;
  localparam int unsigned WordW  = 64;
  localparam int unsigned HalfW  = 32;
  localparam int unsigned ProdW  = 122;
  localparam int unsigned OutW   = 96;

  localparam logic [FieldW-1:0] M61Prime = '1;
  localparam logic [FieldW-1:0] KeyReset = FieldW'(1);

  // Multiplier operand source for the shared modular multiplier
  typedef enum logic [1:0] {
    MSRC_NONE,
    MSRC_KEY,
    MSRC_SQ,
    MSRC_WORD
  } mul_src_e;

  typedef struct packed {
    logic     latch_in;
    mul_src_e mul_src;
    logic     load_cu;
    logic     prep;
    logic     fin;
    logic     fold_res;
    logic     load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic mul_done;
  } dp_sts_t;

  // Reduce a value below 2^62 into [0, p)
  function automatic logic [FieldW-1:0] fold62(input logic [FieldW:0] s);
    logic [FieldW:0] t;
    t = {1'b0, s[FieldW-1:0]} + (FieldW+1)'(s[FieldW]);
    // t is at most 2^61; t - p wraps to t + 1 in 61 bits
    if (t[FieldW] || (t[FieldW-1:0] == M61Prime)) begin
      return t[FieldW-1:0] + FieldW'(1);
    end
    return t[FieldW-1:0];
  endfunction

endpackage

// ===== sv/m61h_mulmod.sv =====
module m61h_mulmod (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [m61h_pkg::FieldW-1:0]  op_a_i,
  input  logic [m61h_pkg::FieldW-1:0]  op_b_i,
  output logic                         done_o,
  output logic [m61h_pkg::FieldW-1:0]  result_o
);

  localparam logic [2:0] StepRed1 = 3'd4;
  localparam logic [2:0] StepRed2 = 3'd5;

  logic                          busy_q, busy_d;
  logic [2:0]                    step_q, step_d;
  logic                          done_q, done_d;
  logic [m61h_pkg::FieldW-1:0]   a_q, b_q;
  logic [m61h_pkg::ProdW-1:0]    acc_q, acc_d;
  logic [m61h_pkg::FieldW:0]     red_q, red_d;
  logic [m61h_pkg::FieldW-1:0]   res_q, res_d;
  logic [m61h_pkg::HalfW-1:0]    limb_a, limb_b;
  logic [2*m61h_pkg::HalfW-1:0]  pp;
  logic [m61h_pkg::ProdW-1:0]    pp_sh;

  // Step 0..3 walks the four 32x32 limb products, steps 4 and 5 reduce
  always_comb begin
    limb_a = step_q[1] ? m61h_pkg::HalfW'(a_q[m61h_pkg::FieldW-1:m61h_pkg::HalfW])
                       : a_q[m61h_pkg::HalfW-1:0];
    limb_b = step_q[0] ? m61h_pkg::HalfW'(b_q[m61h_pkg::FieldW-1:m61h_pkg::HalfW])
                       : b_q[m61h_pkg::HalfW-1:0];
    pp     = limb_a * limb_b;
    case (step_q) inside
      3'd0:       pp_sh = m61h_pkg::ProdW'(pp);
      3'd1, 3'd2: pp_sh = {26'd0, pp, 32'd0};
      3'd3:       pp_sh = {pp[57:0], 64'd0};
      default:    pp_sh = '0;
    endcase
  end

  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    done_d = 1'b0;
    acc_d  = acc_q;
    red_d  = red_q;
    res_d  = res_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      acc_d  = '0;
    end else if (busy_q) begin
      step_d = step_q + 3'd1;
      if (step_q == StepRed1) begin
        // 2^61 == 1 mod p: fold the high part onto the low part
        red_d = {1'b0, acc_q[m61h_pkg::FieldW-1:0]}
              + {1'b0, acc_q[m61h_pkg::ProdW-1:m61h_pkg::FieldW]};
      end else if (step_q == StepRed2) begin
        res_d  = m61h_pkg::fold62(red_q);
        done_d = 1'b1;
        busy_d = 1'b0;
      end else begin
        acc_d = acc_q + pp_sh;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= op_a_i;
      b_q <= op_b_i;
    end
    acc_q <= acc_d;
    red_q <= red_d;
    res_q <= res_d;
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

// ===== sv/m61h_dp.sv =====
module m61h_dp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [m61h_pkg::FieldW-1:0]  cfg_data_i,
  input  logic [m61h_pkg::WordW-1:0]   word_i,
  input  m61h_pkg::dp_cmd_t            cmd_i,
  output m61h_pkg::dp_sts_t            sts_o,
  output logic [m61h_pkg::OutW-1:0]    out_data_o
);

  logic [m61h_pkg::FieldW-1:0] key_q;
  logic [m61h_pkg::FieldW-1:0] x_q, sq_q, cube_q, res_q, out_q;
  logic [m61h_pkg::WordW-1:0]  word_q;
  logic [m61h_pkg::FieldW:0]   su_q, sv_q;
  logic [m61h_pkg::FieldW-1:0] key_red;
  logic                        mul_start, mul_done;
  logic [m61h_pkg::FieldW-1:0] mul_a, mul_b, mul_res;
  logic [m61h_pkg::HalfW-1:0]  term_a, term_b;

  assign key_red = m61h_pkg::fold62({1'b0, key_q});
  assign term_a  = word_q[m61h_pkg::HalfW-1:0];
  assign term_b  = word_q[m61h_pkg::WordW-1:m61h_pkg::HalfW];

  always_comb begin
    mul_start = 1'b1;
    unique case (cmd_i.mul_src)
      m61h_pkg::MSRC_KEY: begin
        mul_a = key_red;
        mul_b = key_red;
      end
      m61h_pkg::MSRC_SQ: begin
        mul_a = mul_res;
        mul_b = x_q;
      end
      m61h_pkg::MSRC_WORD: begin
        mul_a = m61h_pkg::fold62(su_q);
        mul_b = m61h_pkg::fold62(sv_q);
      end
      default: begin
        mul_start = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
      end
    endcase
  end

  m61h_mulmod u_mulmod (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mul_start),
    .op_a_i   (mul_a),
    .op_b_i   (mul_b),
    .done_o   (mul_done),
    .result_o (mul_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= m61h_pkg::KeyReset;
    end else if (cfg_we_i) begin
      key_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) word_q <= word_i;
    if (cmd_i.mul_src == m61h_pkg::MSRC_KEY) x_q <= key_red;
    if (cmd_i.mul_src == m61h_pkg::MSRC_SQ) sq_q <= mul_res;
    if (cmd_i.load_cu) begin
      cube_q <= mul_res;
      res_q  <= x_q;
    end
    if (cmd_i.prep) begin
      su_q <= {1'b0, m61h_pkg::FieldW'(term_b)} + {1'b0, cube_q};
      sv_q <= {1'b0, res_q} + {1'b0, sq_q};
    end
    if (cmd_i.fin) su_q <= {1'b0, m61h_pkg::FieldW'(term_a)} + {1'b0, mul_res};
    if (cmd_i.fold_res) res_q <= m61h_pkg::fold62(su_q);
    if (cmd_i.load_out) out_q <= res_q;
  end

  assign sts_o.mul_done = mul_done;
  assign out_data_o     = {3'd0, out_q[m61h_pkg::HalfW-1:0], out_q};

endmodule

// ===== sv/m61h_ctrl.sv =====
module m61h_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_tvalid_i,
  input  logic              s_tlast_i,
  output logic              s_tready_o,
  input  logic              m_tready_i,
  output logic              m_tvalid_o,
  input  m61h_pkg::dp_sts_t sts_i,
  output m61h_pkg::dp_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WSQ,
    ST_WCU,
    ST_PREP,
    ST_MUL,
    ST_WMUL,
    ST_FOLD,
    ST_OUTW
  } state_e;

  state_e state_q, state_d;
  logic   mid_q, mid_d;
  logic   last_q, last_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || m_tready_i;

  always_comb begin
    state_d     = state_q;
    mid_d       = mid_q;
    last_d      = last_q;
    out_valid_d = out_valid_q && !m_tready_i;
    cmd_o       = '0;
    cmd_o.mul_src = m61h_pkg::MSRC_NONE;
    unique case (state_q)
      ST_IDLE: begin
        if (s_tvalid_i) begin
          cmd_o.latch_in = 1'b1;
          last_d         = s_tlast_i;
          if (mid_q) begin
            state_d = ST_PREP;
          end else begin
            // new message: square the key first
            cmd_o.mul_src = m61h_pkg::MSRC_KEY;
            state_d       = ST_WSQ;
          end
        end
      end
      ST_WSQ: begin
        if (sts_i.mul_done) begin
          cmd_o.mul_src = m61h_pkg::MSRC_SQ;
          state_d       = ST_WCU;
        end
      end
      ST_WCU: begin
        if (sts_i.mul_done) begin
          cmd_o.load_cu = 1'b1;
          state_d       = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mul_src = m61h_pkg::MSRC_WORD;
        state_d       = ST_WMUL;
      end
      ST_WMUL: begin
        if (sts_i.mul_done) begin
          cmd_o.fin = 1'b1;
          state_d   = ST_FOLD;
        end
      end
      ST_FOLD: begin
        cmd_o.fold_res = 1'b1;
        mid_d          = !last_q;
        state_d        = last_q ? ST_OUTW : ST_IDLE;
      end
      ST_OUTW: begin
        // hold the result until the output register frees up
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mid_q       <= 1'b0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mid_q       <= mid_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign s_tready_o = (state_q == ST_IDLE);
  assign m_tvalid_o = out_valid_q;

  a_done_while_waiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.mul_done |-> (state_q == ST_WSQ || state_q == ST_WCU || state_q == ST_WMUL))
    else $error("multiplier finished outside a wait state");

  a_msg_start_keys: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && s_tvalid_i && !mid_q) |=> (state_q == ST_WSQ))
    else $error("first word of a message skipped key powers");

  a_out_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> (!out_valid_q || m_tready_i))
    else $error("pending result overwritten");

  a_mid_after_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FOLD && !last_q) |=> mid_q)
    else $error("message state lost after a non-final word");

endmodule

// ===== sv/mersenne61_polynomial_recurrence_hash.sv =====
// Each word runs through the prep, multiply and fold states before the next word is
// accepted; the first word of a message first squares and cubes the key. The last word
// then loads the output register once it is free, and its result shows there. The shared
// 61-bit modular multiplier (four 32x32 limb steps plus two reduction steps) serves the
// key square, the key cube and every word product.
// Reset (async, active low) clears the message state and sets the key to 1.
module mersenne61_polynomial_recurrence_hash (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [m61h_pkg::FieldW-1:0]  cfg_data_i,    // hash_key
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [m61h_pkg::WordW-1:0]   s_axis_tdata,  // message_word
  input  logic                         s_axis_tlast,  // last_word
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [m61h_pkg::OutW-1:0]    m_axis_tdata   // residue[60:0], hash_low32[92:61]
);

  m61h_pkg::dp_cmd_t cmd;
  m61h_pkg::dp_sts_t sts;

  assign cfg_ready_o = 1'b1;

  m61h_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tlast_i  (s_axis_tlast),
    .s_tready_o (s_axis_tready),
    .m_tready_i (m_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  m61h_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i),
    .cfg_data_i (cfg_data_i),
    .word_i     (s_axis_tdata),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (m_axis_tdata)
  );

endmodule
